/* rtl/core/q31alu_pkg.sv */
// Package for the Q31 saturating ALU: operation codes, Q31 limits and the
// word type that travels along the divider cell chain. No dependencies.
package q31alu_pkg;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } t_kind;

    localparam logic [31:0] QMax = 32'h7FFF_FFFF;
    localparam logic [31:0] QMin = 32'h8000_0000;
    localparam logic signed [63:0] MulBias = 64'sh0000_0000_4000_0000;

    // Thirty-one quotient bits and one rounding bit.
    localparam int NumCells = 32;

    typedef struct packed {
        logic        valid;
        logic        div;
        logic        ovf;
        logic        neg;
        logic [31:0] rem;
        logic [31:0] dvs;
        logic [31:0] quo;
        logic [31:0] res;
    } t_stage;

endpackage

/* rtl/core/q31alu_if.sv */
// Handshake interfaces for the Q31 ALU operation and result words.
// Depends on nothing.
interface q31alu_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    modport source (output valid, kind, operand_a, operand_b, input ready);
    modport sink (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface q31alu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    modport source (output valid, result, input ready);
    modport sink (input valid, result, output ready);
endinterface

/* rtl/core/q31alu_cell.sv */
// One cell of the divider chain: a single restoring division step, with the
// word of a non-divide operation carried through. Depends on q31alu_pkg.
module q31alu_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  q31alu_pkg::t_stage i_st,
    output q31alu_pkg::t_stage o_st
);
    q31alu_pkg::t_stage r_st;
    q31alu_pkg::t_stage n_st;
    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic        w_bit;

    always_comb begin
        w_trial = {i_st.rem, 1'b0};
        w_diff  = w_trial - {1'b0, i_st.dvs};
        w_bit   = (w_trial >= {1'b0, i_st.dvs});
        n_st    = i_st;
        if (i_st.div) begin
            n_st.rem = w_bit ? w_diff[31:0] : w_trial[31:0];
            n_st.quo = {i_st.quo[30:0], w_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;
endmodule

/* rtl/core/q31_saturating_alu_unit.sv */
// Q31 saturating ALU: add, subtract, multiply and divide with saturation.
// Every operation passes through the same pipeline: two set-up stages, 32 divider
// cells with one quotient bit each, and the output register.
// Throughput is one word per cycle; the whole pipeline holds while a result
// waits. Synchronous active-low reset empties the pipeline.
module q31_saturating_alu_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    q31alu_in_if.sink     i_op,
    q31alu_out_if.source  o_res
);
    logic        w_adv;
    logic [32:0] w_sum;
    logic [31:0] w_addsub;
    logic [31:0] w_amag;
    logic [31:0] w_bmag;

    logic               r_a_valid;
    logic [1:0]         r_a_kind;
    logic [31:0]        r_a_res;
    logic signed [63:0] r_a_prod;
    logic [31:0]        r_a_amag;
    logic [31:0]        r_a_bmag;
    logic               r_a_aneg;
    logic               r_a_bneg;
    logic               r_a_bzero;

    logic signed [63:0] w_pb;
    logic signed [63:0] w_q;
    logic [31:0]        w_mul;
    q31alu_pkg::t_stage n_b;
    q31alu_pkg::t_stage r_b;
    q31alu_pkg::t_stage w_cell [0:q31alu_pkg::NumCells];

    logic [32:0] w_round;
    logic [31:0] w_mag;
    logic [31:0] w_divres;
    logic [31:0] n_out;
    logic        r_out_valid;
    logic [31:0] r_out_res;

    assign w_adv       = !r_out_valid || o_res.ready;
    assign i_op.ready  = w_adv;
    assign o_res.valid = r_out_valid;
    assign o_res.result = r_out_res;

    always_comb begin
        if (i_op.kind == q31alu_pkg::KIND_SUB) begin
            w_sum = {i_op.operand_a[31], i_op.operand_a} - {i_op.operand_b[31], i_op.operand_b};
        end else begin
            w_sum = {i_op.operand_a[31], i_op.operand_a} + {i_op.operand_b[31], i_op.operand_b};
        end
        if (w_sum[32] != w_sum[31]) begin
            w_addsub = w_sum[32] ? q31alu_pkg::QMin : q31alu_pkg::QMax;
        end else begin
            w_addsub = w_sum[31:0];
        end
        w_amag = i_op.operand_a[31] ? 32'(-i_op.operand_a) : i_op.operand_a;
        w_bmag = i_op.operand_b[31] ? 32'(-i_op.operand_b) : i_op.operand_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_op.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_kind  <= i_op.kind;
            r_a_res   <= w_addsub;
            r_a_prod  <= i_op.operand_a * i_op.operand_b;
            r_a_amag  <= w_amag;
            r_a_bmag  <= w_bmag;
            r_a_aneg  <= i_op.operand_a[31];
            r_a_bneg  <= i_op.operand_b[31];
            r_a_bzero <= (i_op.operand_b == 32'sd0);
        end
    end

    always_comb begin
        w_pb  = r_a_prod + q31alu_pkg::MulBias;
        w_q   = w_pb >>> 31;
        w_mul = (!w_q[63] && w_q[31]) ? q31alu_pkg::QMax : w_q[31:0];
        n_b.valid = r_a_valid;
        n_b.div   = (r_a_kind == q31alu_pkg::KIND_DIV);
        n_b.ovf   = r_a_bzero || (r_a_amag >= r_a_bmag);
        n_b.neg   = r_a_bzero ? r_a_aneg : (r_a_aneg ^ r_a_bneg);
        n_b.rem   = r_a_amag;
        n_b.dvs   = r_a_bmag;
        n_b.quo   = '0;
        n_b.res   = (r_a_kind == q31alu_pkg::KIND_MUL) ? w_mul : r_a_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b <= '0;
        end else if (w_adv) begin
            r_b <= n_b;
        end
    end

    assign w_cell[0] = r_b;

    for (genvar g = 0; g < q31alu_pkg::NumCells; g++) begin : g_cell
        q31alu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_st    (w_cell[g]),
            .o_st    (w_cell[g+1])
        );
    end

    always_comb begin
        w_round = {1'b0, w_cell[q31alu_pkg::NumCells].quo} + 33'd1;
        w_mag   = w_round[32:1];
        if (w_cell[q31alu_pkg::NumCells].ovf) begin
            w_divres = w_cell[q31alu_pkg::NumCells].neg ? q31alu_pkg::QMin : q31alu_pkg::QMax;
        end else if (w_cell[q31alu_pkg::NumCells].neg) begin
            w_divres = 32'(-w_mag);
        end else if (w_mag == q31alu_pkg::QMin) begin
            w_divres = q31alu_pkg::QMax;
        end else begin
            w_divres = w_mag;
        end
        n_out = w_cell[q31alu_pkg::NumCells].div ? w_divres : w_cell[q31alu_pkg::NumCells].res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_cell[q31alu_pkg::NumCells].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_res <= n_out;
        end
    end
endmodule

/* rtl/core/q31alu_checker.sv */
// Port checker for the Q31 saturating ALU, bound to the top level.
// Depends on q31_saturating_alu_unit.
module q31alu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_result
);
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("Input ready does not follow the output stall.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("A result word appeared straight after reset.");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("A stalled result word was dropped.");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_result))
        else $error("A stalled result word changed.");
endmodule

bind q31_saturating_alu_unit q31alu_checker u_q31alu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_op.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_result (o_res.result)
);
